>>> src/pfns_pkg.sv
// shared constants, result type and helpers for the positive four-neighbor sum block
package pfns_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 128;
  localparam int DATA_WIDTH = 16;

  localparam int CFG_W     = 8;
  localparam int SUM_W     = 17;
  localparam int IDX_W     = 7;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int COL_LIM_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_LIM_W = $clog2(MAX_ROWS + 1);

  // result queue sizing
  localparam int MAX_RESULTS = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_index_t;

  // one result item
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_item;
    logic             last_frame;
  } result_t;

  // strictly positive part of a two's complement sample
  function automatic logic [SUM_W-1:0] pos_part(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? '0 : SUM_W'(v);
  endfunction

endpackage

>>> src/pfns_cell.sv
// one line-store cell: a column slot of the previous and the older row
module pfns_cell import pfns_pkg::*; (
  input  logic                  clk,
  input  logic                  shift,
  input  logic                  head,
  input  logic [DATA_WIDTH-1:0] in_a,
  input  logic [DATA_WIDTH-1:0] in_b,
  input  logic [DATA_WIDTH-1:0] prev_a,
  input  logic [DATA_WIDTH-1:0] prev_b,
  output logic [DATA_WIDTH-1:0] a,
  output logic [DATA_WIDTH-1:0] b
);

  // the head cell loads the new sample, the others take their neighbor
  always_ff @(posedge clk) begin
    if (shift) begin
      a <= head ? in_a : prev_a;
      b <= head ? in_b : prev_b;
    end
  end

endmodule

>>> src/pfns_outq.sv
// result queue: takes up to three results per pixel, hands out one per transfer
module pfns_outq import pfns_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [MAX_RESULTS-1:0] cand_valid,
  input  result_t                cand [MAX_RESULTS],
  output logic                   space_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output result_t                out_data
);

  result_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   off [MAX_RESULTS];
  logic [QCNT_W-1:0]   push_n;
  logic                pop;

  // pack valid candidates in order
  always_comb begin
    logic [QCNT_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      off[j] = QPTR_W'(acc);
      acc    = acc + QCNT_W'(cand_valid[j]);
    end
    push_n = push ? acc : '0;
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign space_ok  = (count <= QCNT_W'(QDEPTH - MAX_RESULTS));

  // storage
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (push && cand_valid[j]) begin
        slots[wr_ptr + off[j]] <= cand[j];
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + push_n - QCNT_W'(pop);
    end
  end

endmodule

>>> src/positive_four_neighbor_sum.sv
// top level: sum of strictly positive four-neighbors over a raster-order matrix
//
//   channel   signals                                           direction
//   input     in_valid, in_ready, pixel_value                   in
//   output    out_valid, out_ready, neighbor_sum, row_index,    out
//             col_index, last_of_item, last_of_frame
//   config    cfg_wr_en, cfg_index, cfg_data                    in
//
// one pixel per cycle while in_ready is high; results leave one per cycle, while
// out_ready is high, from a four-entry queue; pixels of the last row give up to
// two results each (three for the final pixel); input is taken only while the
// queue has room for three; results are registered in the queue on pixel transfer
// reset clears counters and the queue; dimensions return to one by one
// line stores are two chains of cells whose active length follows num_cols
module positive_four_neighbor_sum import pfns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [DATA_WIDTH-1:0] pixel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      neighbor_sum,
  output logic [IDX_W-1:0]      row_index,
  output logic [IDX_W-1:0]      col_index,
  output logic                  last_of_item,
  output logic                  last_of_frame
);

  logic [ROW_LIM_W-1:0]  rows_lim;
  logic [COL_LIM_W-1:0]  cols_lim;
  logic [COL_W-1:0]      head_pos;
  logic [ROW_W-1:0]      row_cnt;
  logic [COL_W-1:0]      col_cnt;
  logic [DATA_WIDTH-1:0] d1;
  logic [DATA_WIDTH-1:0] d2;
  logic [DATA_WIDTH-1:0] ax;
  logic [DATA_WIDTH-1:0] line_a [MAX_COLS];
  logic [DATA_WIDTH-1:0] line_b [MAX_COLS];
  logic [DATA_WIDTH-1:0] a_last;
  logic [DATA_WIDTH-1:0] a_sec;
  logic [DATA_WIDTH-1:0] b_last;
  logic [DATA_WIDTH-1:0] pix;

  logic                   in_fire;
  logic                   last_row;
  logic                   last_col;
  logic                   row_nz;
  logic                   row_gt1;
  logic                   col_nz;
  logic                   col_gt1;
  logic [MAX_RESULTS-1:0] cand_valid;
  result_t                cand [MAX_RESULTS];
  result_t                out_data;

  function automatic logic [ROW_LIM_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    if (v == '0) return ROW_LIM_W'(1);
    if (32'(v) > MAX_ROWS) return ROW_LIM_W'(MAX_ROWS);
    return ROW_LIM_W'(v);
  endfunction

  function automatic logic [COL_LIM_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    if (v == '0) return COL_LIM_W'(1);
    if (32'(v) > MAX_COLS) return COL_LIM_W'(MAX_COLS);
    return COL_LIM_W'(v);
  endfunction

  assign pix     = pixel_value;
  assign in_fire = in_valid && in_ready;

  // position flags
  assign last_row = (ROW_LIM_W'(row_cnt) == rows_lim - ROW_LIM_W'(1));
  assign last_col = (COL_LIM_W'(col_cnt) == cols_lim - COL_LIM_W'(1));
  assign row_nz   = (row_cnt != '0);
  assign row_gt1  = (row_cnt > ROW_W'(1));
  assign col_nz   = (col_cnt != '0);
  assign col_gt1  = (col_cnt > COL_W'(1));

  // taps at the fixed end of the chain
  assign a_last = line_a[MAX_COLS-1];
  assign a_sec  = line_a[MAX_COLS-2];
  assign b_last = line_b[MAX_COLS-1];

  // chain of line-store cells, loaded at head_pos
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_a;
    logic [DATA_WIDTH-1:0] prev_b;
    if (i == 0) begin : g_first
      assign prev_a = pix;
      assign prev_b = a_last;
    end else begin : g_rest
      assign prev_a = line_a[i-1];
      assign prev_b = line_b[i-1];
    end
    pfns_cell u_cell (
      .clk    (clk),
      .shift  (in_fire),
      .head   (head_pos == COL_W'(i)),
      .in_a   (pix),
      .in_b   (a_last),
      .prev_a (prev_a),
      .prev_b (prev_b),
      .a      (line_a[i]),
      .b      (line_b[i])
    );
  end

  // recent samples of the current row and the one just past the line store
  always_ff @(posedge clk) begin
    if (in_fire) begin
      d1 <= pix;
      d2 <= d1;
      ax <= a_last;
    end
  end

  // result candidates for this pixel
  always_comb begin
    cand_valid[0] = row_nz;
    cand_valid[1] = last_row && col_nz;
    cand_valid[2] = last_row && last_col;

    // element above the current pixel
    cand[0].sum = pos_part(pix)
                + (row_gt1 ? pos_part(b_last) : '0)
                + (col_nz ? pos_part(ax) : '0)
                + (!last_col ? pos_part(a_sec) : '0);
    cand[0].row        = IDX_W'(row_cnt - ROW_W'(1));
    cand[0].col        = IDX_W'(col_cnt);
    cand[0].last_item  = !cand_valid[1] && !cand_valid[2];
    cand[0].last_frame = 1'b0;

    // last row, element to the left
    cand[1].sum = pos_part(pix)
                + (col_gt1 ? pos_part(d2) : '0)
                + (row_nz ? pos_part(ax) : '0);
    cand[1].row        = IDX_W'(row_cnt);
    cand[1].col        = IDX_W'(col_cnt - COL_W'(1));
    cand[1].last_item  = !cand_valid[2];
    cand[1].last_frame = 1'b0;

    // bottom-right element
    cand[2].sum = (col_nz ? pos_part(d1) : '0)
                + (row_nz ? pos_part(a_last) : '0);
    cand[2].row        = IDX_W'(row_cnt);
    cand[2].col        = IDX_W'(col_cnt);
    cand[2].last_item  = 1'b1;
    cand[2].last_frame = 1'b1;
  end

  pfns_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire),
    .cand_valid (cand_valid),
    .cand       (cand),
    .space_ok   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign neighbor_sum  = out_data.sum;
  assign row_index     = out_data.row;
  assign col_index     = out_data.col;
  assign last_of_item  = out_data.last_item;
  assign last_of_frame = out_data.last_frame;

  // configuration registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_lim <= ROW_LIM_W'(1);
      cols_lim <= COL_LIM_W'(1);
      head_pos <= COL_W'(MAX_COLS - 1);
      row_cnt  <= '0;
      col_cnt  <= '0;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_NUM_ROWS: begin
          rows_lim <= clamp_rows(cfg_data);
        end
        REG_NUM_COLS: begin
          cols_lim <= clamp_cols(cfg_data);
          head_pos <= COL_W'(MAX_COLS - int'(clamp_cols(cfg_data)));
        end
        default: begin
        end
      endcase
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // frame end returns the raster position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_row && last_col |=> row_cnt == '0 && col_cnt == '0)
    else $error("position did not wrap at frame end");

  // rows between the first and the last give exactly one result per pixel
  a_one_result_mid: assert property (@(posedge clk) disable iff (rst)
    in_fire && row_nz && !last_row |-> $countones(cand_valid) == 1)
    else $error("wrong result count for a middle row pixel");

  // the bottom-right result always closes its pixel's results
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> last_of_item)
    else $error("frame end result not marked last of item");

endmodule
